@@ rtl/plcc_pkg.sv @@
// Shared types, codes and constants of the phone line call controller.
package plcc_pkg;

    localparam int NUM_LINES = 16;
    localparam int LINE_AW   = $clog2(NUM_LINES);

    localparam logic [4:0] DIGIT_MAX  = 5'd19;
    localparam logic [4:0] NO_PARTNER = 5'd16;
    localparam logic [3:0] PLAN_SIZE  = 4'd8;

    // Line modes.
    localparam logic [3:0] M_UNINIT  = 4'd0;
    localparam logic [3:0] M_IDLE    = 4'd1;
    localparam logic [3:0] M_DIAL    = 4'd2;
    localparam logic [3:0] M_AWAIT   = 4'd3;
    localparam logic [3:0] M_REQRING = 4'd4;
    localparam logic [3:0] M_RINGING = 4'd5;
    localparam logic [3:0] M_TRAFFIC = 4'd6;
    localparam logic [3:0] M_BUSY    = 4'd8;
    localparam logic [3:0] M_UNREACH = 4'd9;

    // Handset states reported by a poll.
    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DIAL    = 3'd1;
    localparam logic [2:0] S_RING    = 3'd2;
    localparam logic [2:0] S_TRAFFIC = 3'd3;
    localparam logic [2:0] S_UNREACH = 3'd4;

    // Commands to the line.
    localparam logic [2:0] C_NONE    = 3'd0;
    localparam logic [2:0] C_RING    = 3'd1;
    localparam logic [2:0] C_DISMISS = 3'd2;
    localparam logic [2:0] C_PLAIN   = 3'd3;
    localparam logic [2:0] C_DISC    = 3'd4;

    // Tone recordings.
    localparam logic [1:0] T_DIAL     = 2'd0;
    localparam logic [1:0] T_BUSY     = 2'd1;
    localparam logic [1:0] T_RINGBACK = 2'd2;

    localparam logic [7:0] ASCII_0 = 8'h30;
    localparam logic [7:0] ASCII_1 = 8'h31;
    localparam logic [7:0] ASCII_8 = 8'h38;

    // Configuration register map.
    localparam int         CFG_AW       = 3;
    localparam logic [0:0] REG_DIALABLE = 1'b0;
    localparam logic [3:0] DIALABLE_RST = 4'd8;

    typedef struct packed {
        logic [3:0] line_index;
        logic [2:0] phone_status;
        logic [7:0] dial_digit;
    } t_in;

    typedef struct packed {
        logic [2:0] command;
        logic [3:0] line_mode;
        logic [4:0] partner_line;
        logic       tone_on;
        logic [1:0] tone_select;
    } t_out;

    // Everything the block keeps for one line but its valid flag, stored as one memory word.
    typedef struct packed {
        logic [3:0]  mode;
        logic [4:0]  partner;
        logic [2:0]  pending;
        logic [4:0]  count;
        logic [15:0] digits;
        logic        tone_on;
        logic [1:0]  tone_sel;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    localparam t_entry RESET_ENTRY = '{
        mode:     M_UNINIT,
        partner:  NO_PARTNER,
        pending:  C_NONE,
        count:    5'd0,
        digits:   16'h0000,
        tone_on:  1'b0,
        tone_sel: T_DIAL
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_CALC,
        ST_OTHER
    } t_state;

    typedef enum logic [1:0] {
        OTH_NONE,
        OTH_CLEAR,
        OTH_RING
    } t_oth_op;

    typedef struct packed {
        logic accept;
        logic eval;
        logic calc;
        logic oth_wr;
    } t_dp_cmd;

    typedef struct packed {
        logic need_other;
    } t_dp_stat;

endpackage

@@ rtl/plcc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module plcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/plcc_dp.sv @@
// Datapath: line table memory, valid flags, call state update and result register.
module plcc_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  plcc_pkg::t_dp_cmd i_cmd,
    input  plcc_pkg::t_in     i_item,
    input  logic [3:0]        i_dialable,
    output plcc_pkg::t_dp_stat o_stat,
    output plcc_pkg::t_out    o_result
);

    localparam int AW = plcc_pkg::LINE_AW;

    plcc_pkg::t_in     r_item;
    plcc_pkg::t_entry  r_ent;
    plcc_pkg::t_out    r_result;
    plcc_pkg::t_oth_op r_oth_op;
    logic [AW-1:0]     r_oth_tgt;
    logic [plcc_pkg::NUM_LINES-1:0] r_valid;
    logic              r_rd_valid;

    logic [plcc_pkg::ENTRY_W-1:0] ram_rdata;
    logic [plcc_pkg::ENTRY_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [AW-1:0]     ram_waddr;
    logic              ram_we;

    plcc_pkg::t_entry  q_ent;
    plcc_pkg::t_entry  n_ent;
    plcc_pkg::t_entry  oth_ent;
    plcc_pkg::t_entry  w_ent;
    plcc_pkg::t_out    n_result;
    plcc_pkg::t_oth_op n_oth_op;
    logic [AW-1:0]     n_oth_tgt;
    logic [AW-1:0]     own_line;
    logic              in_range;

    // Update terms.
    logic [3:0]  mode;
    logic [4:0]  part;
    logic [2:0]  pend;
    logic [4:0]  cnt;
    logic [15:0] dig;
    logic        ton;
    logic [1:0]  tsel;
    logic [3:0]  pmode;
    logic        p_is_line;
    logic [3:0]  limit;
    logic [7:0]  d1_off;
    logic        dial_hit;
    logic [AW-1:0] dial_line;

    assign own_line = r_item.line_index[AW-1:0];
    assign in_range = {1'b0, r_item.line_index} < 5'(plcc_pkg::NUM_LINES);

    // An entry never written reads as its reset value.
    assign q_ent = r_rd_valid ? plcc_pkg::t_entry'(ram_rdata) : plcc_pkg::RESET_ENTRY;

    always_comb begin
        mode      = r_ent.mode;
        part      = r_ent.partner;
        pend      = r_ent.pending;
        cnt       = r_ent.count;
        dig       = r_ent.digits;
        ton       = r_ent.tone_on;
        tsel      = r_ent.tone_sel;
        pmode     = q_ent.mode;
        n_oth_op  = plcc_pkg::OTH_NONE;
        n_oth_tgt = part[AW-1:0];
        p_is_line = part < 5'(plcc_pkg::NUM_LINES);

        // Two-digit dial plan match "0N" -> line N-1.
        limit     = (i_dialable > plcc_pkg::PLAN_SIZE) ? plcc_pkg::PLAN_SIZE : i_dialable;
        d1_off    = dig[15:8] - plcc_pkg::ASCII_1;
        dial_hit  = (cnt == 5'd2) && (dig[7:0] == plcc_pkg::ASCII_0)
                    && (dig[15:8] >= plcc_pkg::ASCII_1) && (dig[15:8] <= plcc_pkg::ASCII_8)
                    && (d1_off[3:0] < limit)
                    && ({1'b0, d1_off[3:0]} < 5'(plcc_pkg::NUM_LINES));
        dial_line = d1_off[AW-1:0];

        // Hang-up, except on a line in REQRING, clears the partner link on both sides.
        if (r_item.phone_status == plcc_pkg::S_IDLE && mode != plcc_pkg::M_IDLE
                && mode != plcc_pkg::M_REQRING) begin
            if (part != plcc_pkg::NO_PARTNER) begin
                if (p_is_line && part[AW-1:0] != own_line) begin
                    n_oth_op = plcc_pkg::OTH_CLEAR;
                end
                part = plcc_pkg::NO_PARTNER;
            end
            mode = plcc_pkg::M_IDLE;
        end

        unique case (mode)
            plcc_pkg::M_IDLE: begin
                ton = 1'b0;
                if (r_item.phone_status == plcc_pkg::S_DIAL) begin
                    mode = plcc_pkg::M_DIAL;
                    ton  = 1'b1;
                    tsel = plcc_pkg::T_DIAL;
                end
                if (cnt != 5'd0) begin
                    cnt = 5'd0;
                    dig = 16'h0000;
                    ton = 1'b0;
                end
            end
            plcc_pkg::M_DIAL: begin
                if (cnt != 5'd0) begin
                    ton = 1'b0;
                end
                if (part == plcc_pkg::NO_PARTNER && dial_hit) begin
                    ton  = 1'b1;
                    tsel = plcc_pkg::T_RINGBACK;
                    // A self call lands the ring request on this line itself.
                    if (dial_line == own_line) begin
                        pend = plcc_pkg::C_RING;
                        part = {1'b0, r_item.line_index};
                        mode = plcc_pkg::M_REQRING;
                    end else begin
                        part      = 5'(dial_line);
                        mode      = plcc_pkg::M_AWAIT;
                        n_oth_op  = plcc_pkg::OTH_RING;
                        n_oth_tgt = dial_line;
                    end
                end
            end
            plcc_pkg::M_AWAIT: begin
                if (!p_is_line) begin
                    mode = plcc_pkg::M_BUSY;
                    ton  = 1'b1;
                    tsel = plcc_pkg::T_BUSY;
                end else if (pmode == plcc_pkg::M_TRAFFIC) begin
                    pend = plcc_pkg::C_PLAIN;
                    mode = plcc_pkg::M_TRAFFIC;
                    ton  = 1'b0;
                end else if (pmode == plcc_pkg::M_UNREACH) begin
                    mode = plcc_pkg::M_BUSY;
                    ton  = 1'b1;
                    tsel = plcc_pkg::T_BUSY;
                end
            end
            plcc_pkg::M_REQRING: begin
                if (r_item.phone_status == plcc_pkg::S_UNREACH) begin
                    mode = plcc_pkg::M_UNREACH;
                    part = plcc_pkg::NO_PARTNER;
                end
                if (r_item.phone_status == plcc_pkg::S_RING) begin
                    mode = plcc_pkg::M_RINGING;
                end
            end
            plcc_pkg::M_RINGING: begin
                if (part == plcc_pkg::NO_PARTNER) begin
                    pend = plcc_pkg::C_DISMISS;
                end else if (r_item.phone_status == plcc_pkg::S_TRAFFIC) begin
                    mode = plcc_pkg::M_TRAFFIC;
                end
            end
            plcc_pkg::M_TRAFFIC: begin
                ton = 1'b0;
                if (!p_is_line) begin
                    pend = plcc_pkg::C_DISC;
                    mode = plcc_pkg::M_DIAL;
                    cnt  = 5'd0;
                    dig  = 16'h0000;
                    ton  = 1'b1;
                    tsel = plcc_pkg::T_DIAL;
                end else if (pmode == plcc_pkg::M_UNREACH) begin
                    mode = plcc_pkg::M_BUSY;
                    ton  = 1'b1;
                    tsel = plcc_pkg::T_BUSY;
                end
            end
            plcc_pkg::M_UNREACH: begin
                if (part != plcc_pkg::NO_PARTNER) begin
                    if (p_is_line && part[AW-1:0] != own_line) begin
                        n_oth_op = plcc_pkg::OTH_CLEAR;
                    end
                    part = plcc_pkg::NO_PARTNER;
                end
            end
            default: begin
            end
        endcase

        // Only the first two digits are kept; the count saturates.
        if (r_item.dial_digit != 8'h00 && cnt < plcc_pkg::DIGIT_MAX) begin
            if (cnt == 5'd0) begin
                dig[7:0] = r_item.dial_digit;
            end else if (cnt == 5'd1) begin
                dig[15:8] = r_item.dial_digit;
            end
            cnt = cnt + 5'd1;
        end

        n_ent.mode     = mode;
        n_ent.partner  = part;
        n_ent.pending  = plcc_pkg::C_NONE;
        n_ent.count    = cnt;
        n_ent.digits   = dig;
        n_ent.tone_on  = ton;
        n_ent.tone_sel = tsel;

        if (in_range) begin
            n_result.command      = pend;
            n_result.line_mode    = mode;
            n_result.partner_line = part;
            n_result.tone_on      = ton;
            n_result.tone_select  = tsel;
        end else begin
            n_result.command      = plcc_pkg::C_NONE;
            n_result.line_mode    = plcc_pkg::M_UNINIT;
            n_result.partner_line = plcc_pkg::NO_PARTNER;
            n_result.tone_on      = 1'b0;
            n_result.tone_select  = plcc_pkg::T_DIAL;
            n_oth_op              = plcc_pkg::OTH_NONE;
        end
    end

    // Read-modify-write of the other line's entry.
    always_comb begin
        oth_ent = q_ent;
        if (r_oth_op == plcc_pkg::OTH_RING) begin
            oth_ent.pending = plcc_pkg::C_RING;
            oth_ent.partner = {1'b0, r_item.line_index};
            oth_ent.mode    = plcc_pkg::M_REQRING;
        end else begin
            oth_ent.partner = plcc_pkg::NO_PARTNER;
        end
    end

    always_comb begin
        if (i_cmd.accept) begin
            ram_raddr = i_item.line_index[AW-1:0];
        end else if (i_cmd.eval) begin
            ram_raddr = q_ent.partner[AW-1:0];
        end else if (i_cmd.calc) begin
            ram_raddr = n_oth_tgt;
        end else begin
            ram_raddr = own_line;
        end
    end

    assign ram_we    = (i_cmd.calc && in_range) || i_cmd.oth_wr;
    assign ram_waddr = i_cmd.oth_wr ? r_oth_tgt : own_line;
    assign w_ent     = i_cmd.oth_wr ? oth_ent : n_ent;
    assign ram_wdata = w_ent;

    plcc_ram #(
        .WIDTH(plcc_pkg::ENTRY_W),
        .DEPTH(plcc_pkg::NUM_LINES)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (ram_we) begin
            r_valid[ram_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_valid <= r_valid[ram_raddr];
        if (i_cmd.accept) begin
            r_item <= i_item;
        end
        if (i_cmd.eval) begin
            r_ent <= q_ent;
        end
        if (i_cmd.calc) begin
            r_result  <= n_result;
            r_oth_op  <= n_oth_op;
            r_oth_tgt <= n_oth_tgt;
        end
    end

    assign o_stat.need_other = in_range && (n_oth_op != plcc_pkg::OTH_NONE);
    assign o_result          = r_result;

    a_oth_not_own: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.oth_wr |-> (r_oth_tgt != own_line))
        else $error("other-line write aimed at the polled line");

    a_partner_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (w_ent.partner <= plcc_pkg::NO_PARTNER))
        else $error("partner link written out of range");

endmodule

@@ rtl/plcc_ctrl.sv @@
// Controller: sequences the table reads and writes of one poll.
module plcc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  plcc_pkg::t_dp_stat i_stat,
    output plcc_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy,
    output logic               o_done
);

    plcc_pkg::t_state r_state;
    plcc_pkg::t_state n_state;
    logic             r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plcc_pkg::ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == plcc_pkg::ST_CALC);
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            plcc_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = plcc_pkg::ST_EVAL;
                end
            end
            plcc_pkg::ST_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = plcc_pkg::ST_CALC;
            end
            plcc_pkg::ST_CALC: begin
                o_cmd.calc = 1'b1;
                n_state    = i_stat.need_other ? plcc_pkg::ST_OTHER : plcc_pkg::ST_IDLE;
            end
            plcc_pkg::ST_OTHER: begin
                o_cmd.oth_wr = 1'b1;
                n_state      = plcc_pkg::ST_IDLE;
            end
            default: begin
                n_state = plcc_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != plcc_pkg::ST_IDLE);
    assign o_done = r_done;

    a_other_after_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == plcc_pkg::ST_OTHER) |-> $past(r_state == plcc_pkg::ST_CALC))
        else $error("other-line write without a preceding update");

endmodule

@@ rtl/phone_line_call_controller.sv @@
// Top level of the phone line call controller: APB register and unit wiring.
//
// Usage: each poll item (line_index, phone_status, dial_digit) is offered on
// i_item with start; it is taken at a rising edge where start is high and busy
// is low. The block updates that line's call state and answers with one result
// item (command, line_mode, partner_line, tone_on, tone_select) on o_result,
// valid for exactly one cycle while o_done is high, after the CALC state. The
// receiver cannot stall the result. An item runs through EVAL and CALC, and
// OTHER too when the poll changes another line's entry (ring request or
// partner release). The per-line state sits in one table memory with one read
// and one write port, read and written in a read-modify-write sequence, and
// that sequence sets the rate. dialable_lines is written over the APB port at
// byte address 0; the user must do so only while the block is idle, which the
// block does not enforce. Reset sets dialable_lines to 8 and clears the per-line
// valid flags, so every line reads its reset state at once; no clearing pass runs.
module phone_line_call_controller (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  plcc_pkg::t_in             i_item,
    output logic                      o_done,
    output plcc_pkg::t_out            o_result,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [plcc_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    logic [3:0]         r_dialable;
    plcc_pkg::t_dp_cmd  dp_cmd;
    plcc_pkg::t_dp_stat dp_stat;
    logic               cfg_wr;
    logic               cfg_hit;

    assign pready  = 1'b1;
    assign cfg_hit = (paddr[plcc_pkg::CFG_AW-1:2] == plcc_pkg::REG_DIALABLE);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
    assign prdata  = cfg_hit ? {28'h0000000, r_dialable} : 32'h00000000;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dialable <= plcc_pkg::DIALABLE_RST;
        end else if (cfg_wr) begin
            r_dialable <= pwdata[3:0];
        end
    end

    plcc_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_stat (dp_stat),
        .o_cmd  (dp_cmd),
        .o_busy (busy),
        .o_done (o_done)
    );

    plcc_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (dp_cmd),
        .i_item    (i_item),
        .i_dialable(r_dialable),
        .o_stat    (dp_stat),
        .o_result  (o_result)
    );

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##3 o_done)
        else $error("result not delivered two cycles after accept");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("more than one result for an item");

endmodule

@@ tb/call_tracker_pkg.sv @@
// Call state tracker that predicts and checks the controller's result items.
package call_tracker_pkg;

    import plcc_pkg::*;

    class call_tracker;
        logic [3:0] dialable;
        logic [3:0] mode_of [NUM_LINES];
        logic [4:0] partner_of [NUM_LINES];
        logic [2:0] pending_of [NUM_LINES];
        logic [4:0] count_of [NUM_LINES];
        logic [7:0] first_digit [NUM_LINES];
        logic [7:0] second_digit [NUM_LINES];
        logic       tone_of [NUM_LINES];
        logic [1:0] tone_sel_of [NUM_LINES];
        t_out       expected_results [$];
        int         mismatches;

        function new();
            dialable = DIALABLE_RST;
            mismatches = 0;
            for (int k = 0; k < NUM_LINES; k++) begin
                mode_of[k] = M_UNINIT;
                partner_of[k] = NO_PARTNER;
                pending_of[k] = C_NONE;
                count_of[k] = '0;
                first_digit[k] = '0;
                second_digit[k] = '0;
                tone_of[k] = 1'b0;
                tone_sel_of[k] = T_DIAL;
            end
        endfunction

        // Line reached by a complete "0N" number, or -1 when nothing matches.
        function int number_target(int ln);
            int limit;
            int n;
            limit = (dialable > PLAN_SIZE) ? int'(PLAN_SIZE) : int'(dialable);
            if (count_of[ln] != 5'd2 || first_digit[ln] != ASCII_0)
                return -1;
            if (second_digit[ln] < ASCII_1 || second_digit[ln] > ASCII_8)
                return -1;
            n = int'(second_digit[ln] - ASCII_1);
            if (n >= limit || n >= NUM_LINES)
                return -1;
            return n;
        endfunction

        function void set_tone(int ln, logic [1:0] sel);
            tone_of[ln] = 1'b1;
            tone_sel_of[ln] = sel;
        endfunction

        function void release_partner(int ln);
            int p;
            p = int'(partner_of[ln]);
            if (partner_of[ln] != NO_PARTNER) begin
                if (p < NUM_LINES)
                    partner_of[p] = NO_PARTNER;
                partner_of[ln] = NO_PARTNER;
            end
        endfunction

        function void advance_line(int ln, logic [2:0] st);
            logic [3:0] m;
            int p;
            int t;
            m = mode_of[ln];
            // An on-hook poll ends any call, except on a line that is about to ring.
            if (st == S_IDLE && m != M_IDLE && m != M_REQRING) begin
                release_partner(ln);
                mode_of[ln] = M_IDLE;
                m = M_IDLE;
            end
            p = int'(partner_of[ln]);
            case (m)
                M_IDLE: begin
                    tone_of[ln] = 1'b0;
                    if (st == S_DIAL) begin
                        mode_of[ln] = M_DIAL;
                        set_tone(ln, T_DIAL);
                    end
                    if (count_of[ln] > 0) begin
                        count_of[ln] = '0;
                        first_digit[ln] = '0;
                        second_digit[ln] = '0;
                        tone_of[ln] = 1'b0;
                    end
                end
                M_DIAL: begin
                    if (count_of[ln] > 0)
                        tone_of[ln] = 1'b0;
                    t = number_target(ln);
                    if (partner_of[ln] == NO_PARTNER && t >= 0) begin
                        partner_of[ln] = 5'(t);
                        mode_of[ln] = M_AWAIT;
                        set_tone(ln, T_RINGBACK);
                        // On a self call these writes land on the caller itself.
                        pending_of[t] = C_RING;
                        partner_of[t] = 5'(ln);
                        mode_of[t] = M_REQRING;
                    end
                end
                M_AWAIT: begin
                    if (p >= NUM_LINES) begin
                        mode_of[ln] = M_BUSY;
                        set_tone(ln, T_BUSY);
                    end else if (mode_of[p] == M_TRAFFIC) begin
                        pending_of[ln] = C_PLAIN;
                        mode_of[ln] = M_TRAFFIC;
                        tone_of[ln] = 1'b0;
                    end else if (mode_of[p] == M_UNREACH) begin
                        mode_of[ln] = M_BUSY;
                        set_tone(ln, T_BUSY);
                    end
                end
                M_REQRING: begin
                    if (st == S_UNREACH) begin
                        mode_of[ln] = M_UNREACH;
                        partner_of[ln] = NO_PARTNER;
                    end
                    if (st == S_RING)
                        mode_of[ln] = M_RINGING;
                end
                M_RINGING: begin
                    if (partner_of[ln] == NO_PARTNER)
                        pending_of[ln] = C_DISMISS;
                    else if (st == S_TRAFFIC)
                        mode_of[ln] = M_TRAFFIC;
                end
                M_TRAFFIC: begin
                    tone_of[ln] = 1'b0;
                    if (p >= NUM_LINES) begin
                        pending_of[ln] = C_DISC;
                        mode_of[ln] = M_DIAL;
                        count_of[ln] = '0;
                        first_digit[ln] = '0;
                        second_digit[ln] = '0;
                        set_tone(ln, T_DIAL);
                    end else if (mode_of[p] == M_UNREACH) begin
                        mode_of[ln] = M_BUSY;
                        set_tone(ln, T_BUSY);
                    end
                end
                M_UNREACH: release_partner(ln);
                default: ;
            endcase
        endfunction

        function void note_poll(t_in poll);
            int   ln;
            t_out res;
            ln = int'(poll.line_index);
            if (ln >= NUM_LINES) begin
                res = '{command: C_NONE, line_mode: M_UNINIT, partner_line: NO_PARTNER,
                        tone_on: 1'b0, tone_select: T_DIAL};
                expected_results.push_back(res);
                return;
            end
            advance_line(ln, poll.phone_status);
            // The digit goes in after the state update; only two are kept.
            if (poll.dial_digit != 8'h00 && count_of[ln] < DIGIT_MAX) begin
                if (count_of[ln] == 5'd0)
                    first_digit[ln] = poll.dial_digit;
                else if (count_of[ln] == 5'd1)
                    second_digit[ln] = poll.dial_digit;
                count_of[ln] = count_of[ln] + 5'd1;
            end
            res.command = pending_of[ln];
            pending_of[ln] = C_NONE;
            res.line_mode = mode_of[ln];
            res.partner_line = partner_of[ln];
            res.tone_on = tone_of[ln];
            res.tone_select = tone_sel_of[ln];
            expected_results.push_back(res);
        endfunction

        function void check_result(t_out got);
            t_out want;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: cmd=%0d mode=%0d partner=%0d tone=%0b/%0d",
                             got.command, got.line_mode, got.partner_line, got.tone_on,
                             got.tone_select);
                return;
            end
            want = expected_results.pop_front();
            if (got.command !== want.command || got.line_mode !== want.line_mode ||
                got.partner_line !== want.partner_line || got.tone_on !== want.tone_on ||
                got.tone_select !== want.tone_select) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $write("mismatch: expected cmd=%0d mode=%0d partner=%0d tone=%0b/%0d, ",
                           want.command, want.line_mode, want.partner_line, want.tone_on,
                           want.tone_select);
                    $display("got cmd=%0d mode=%0d partner=%0d tone=%0b/%0d",
                             got.command, got.line_mode, got.partner_line, got.tone_on,
                             got.tone_select);
                end
            end
        endfunction
    endclass

endpackage

@@ tb/phone_line_call_controller_test.sv @@
// Top of the call controller testbench: clock, reset, poll and register traffic, checks.
module phone_line_call_controller_test;

    timeunit 1ns;
    timeprecision 1ps;

    import plcc_pkg::*;
    import call_tracker_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int POLLS_PER_PHASE = 150;
    localparam int PHASES = 8;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    t_in               i_item;
    logic              o_done;
    t_out              o_result;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    call_tracker tracker;
    int          burst_left = 0;
    int          polls_sent = 0;
    int          quiet_cycles = 0;

    always #5 i_clk = ~i_clk;

    phone_line_call_controller dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Outputs are read at the edge before any update of this step lands.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done)
                tracker.check_result(o_result);
            if (start && !busy)
                tracker.note_poll(i_item);
            if (o_done || (start && !busy))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic send_poll(input logic [3:0] ln, input logic [2:0] st,
                             input logic [7:0] dg);
        t_in poll;
        int  gap;
        poll.line_index = ln;
        poll.phone_status = st;
        poll.dial_digit = dg;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 7);
            if (gap > 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 100)
                                                    : $urandom_range(1, 12);
        end
        burst_left--;
        start <= 1'b1;
        i_item <= poll;
        do @(posedge i_clk); while (busy);
        polls_sent++;
    endtask

    task automatic send_random_poll();
        send_poll(4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                  ($urandom_range(0, 1) == 1) ? 8'($urandom) : 8'h00);
    endtask

    task automatic maybe_noise();
        if ($urandom_range(0, 5) == 0)
            send_random_poll();
    endtask

    // Holds the sender off until every result is back and the block has settled.
    task automatic settle();
        start <= 1'b0;
        while (tracker.expected_results.size() != 0)
            @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_dialable(input logic [3:0] value);
        logic [31:0] word;
        word = {($urandom_range(0, 1) == 1) ? 28'($urandom) : 28'h0, value};
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_AW'(4 * REG_DIALABLE);
        pwdata <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        tracker.dialable = value;
    endtask

    // One call attempt: dial a number, let the far end react, then hang up.
    task automatic place_call();
        int         caller;
        int         callee;
        int         other;
        int         style;
        int         n_digits;
        logic [7:0] dg;
        caller = $urandom_range(0, 15);
        callee = ($urandom_range(0, 7) == 0) ? caller : $urandom_range(0, 7);
        style = $urandom_range(0, 9);
        if ($urandom_range(0, 3) != 0)
            send_poll(4'(caller), S_IDLE, 8'h00);
        send_poll(4'(caller), S_DIAL, 8'h00);
        maybe_noise();
        if (style <= 6) begin
            send_poll(4'(caller), S_DIAL, ASCII_0);
            maybe_noise();
            send_poll(4'(caller), S_DIAL, 8'(ASCII_1 + callee));
        end else begin
            // Wrong numbers: odd characters, three digits, or a long string.
            n_digits = (style == 7) ? 2 : (style == 8) ? 3 : $urandom_range(17, 23);
            for (int k = 0; k < n_digits; k++) begin
                dg = ($urandom_range(0, 2) == 0) ? 8'($urandom)
                                                 : 8'(ASCII_0 + $urandom_range(0, 9));
                if (dg == 8'h00)
                    dg = ASCII_0;
                send_poll(4'(caller), S_DIAL, dg);
            end
        end
        send_poll(4'(caller), S_DIAL, 8'h00);
        maybe_noise();
        case ($urandom_range(0, 3))
            0: begin
                send_poll(4'(callee), S_RING, 8'h00);
                send_poll(4'(callee), S_TRAFFIC, 8'h00);
                maybe_noise();
                send_poll(4'(caller), S_TRAFFIC, 8'h00);
                send_poll(4'(callee), S_TRAFFIC, 8'h00);
            end
            1: begin
                send_poll(4'(callee), S_UNREACH, 8'h00);
                send_poll(4'(caller), S_DIAL, 8'h00);
                send_poll(4'(callee), S_UNREACH, 8'h00);
            end
            2: begin
                // Caller gives up while the far end rings.
                send_poll(4'(callee), S_RING, 8'h00);
                send_poll(4'(caller), S_IDLE, 8'h00);
                send_poll(4'(callee), S_RING, 8'h00);
            end
            default: begin
                send_random_poll();
                send_poll(4'(caller), 3'($urandom_range(0, 7)), 8'h00);
            end
        endcase
        other = ($urandom_range(0, 1) == 1) ? caller : callee;
        send_poll(4'(other), S_IDLE, 8'h00);
        other = (other == caller) ? callee : caller;
        send_poll(4'(other), S_TRAFFIC, 8'h00);
        if ($urandom_range(0, 1) == 1)
            send_poll(4'(other), S_IDLE, 8'h00);
    endtask

    initial begin
        logic [3:0] setting;
        int         phase_start;
        tracker = new();
        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_item <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening with the reset dial plan size.
        send_poll(4'd0, S_DIAL, 8'hFF);
        send_poll(4'd0, S_IDLE, 8'h00);
        send_poll(4'd15, 3'd7, 8'h00);
        send_poll(4'd15, S_IDLE, 8'h00);
        send_poll(4'd15, 3'd5, ASCII_0);
        send_poll(4'd0, S_DIAL, 8'h00);
        send_poll(4'd0, S_DIAL, ASCII_0);
        send_poll(4'd0, S_DIAL, 8'(ASCII_1 + 1));
        send_poll(4'd0, S_DIAL, 8'h00);
        send_poll(4'd1, S_RING, 8'h00);
        send_poll(4'd1, S_TRAFFIC, 8'h00);
        send_poll(4'd0, S_TRAFFIC, 8'h00);
        send_poll(4'd1, S_IDLE, 8'h00);
        send_poll(4'd0, S_TRAFFIC, 8'h00);
        send_poll(4'd0, S_DIAL, ASCII_0);
        send_poll(4'd0, S_DIAL, ASCII_1);
        send_poll(4'd0, S_DIAL, 8'h00);
        send_poll(4'd0, S_UNREACH, 8'h00);
        send_poll(4'd2, S_IDLE, 8'h00);
        send_poll(4'd2, S_DIAL, 8'h00);
        send_poll(4'd2, S_DIAL, ASCII_0);
        send_poll(4'd2, S_DIAL, ASCII_8);
        send_poll(4'd2, S_DIAL, 8'h00);
        send_poll(4'd7, S_UNREACH, 8'h00);
        send_poll(4'd2, S_DIAL, 8'h00);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase > 0) begin
                case (phase)
                    1: setting = 4'd0;
                    2: setting = 4'd15;
                    3: setting = 4'd1;
                    4: setting = 4'($urandom_range(2, 7));
                    5: setting = 4'd8;
                    6: setting = 4'($urandom_range(9, 14));
                    default: setting = 4'($urandom_range(0, 15));
                endcase
                settle();
                write_dialable(setting);
            end
            phase_start = polls_sent;
            while (polls_sent - phase_start < POLLS_PER_PHASE) begin
                if ($urandom_range(0, 3) == 0)
                    send_random_poll();
                else
                    place_call();
                if ($urandom_range(0, 19) == 0)
                    settle();
            end
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (tracker.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
